// File: design/scfla_pkg.sv
// Shared types, constants and the size-class lookup for the free-list allocator.
package scfla_pkg;

   localparam int MIN_SHIFT     = 6;
   localparam int MAX_SHIFT     = 12;
   localparam int NCLASSES      = MAX_SHIFT - MIN_SHIFT + 1;
   localparam int PAGE_BYTES    = 4096;
   localparam int ADDR_BITS     = 18;
   localparam int NBYTES_BITS   = 13;
   localparam int CPU_FIELD_BITS = 3;
   localparam int CLASS_BITS    = 4;
   localparam int PAGE_HI_BITS  = ADDR_BITS - MAX_SHIFT;
   localparam int CHUNK_RAW_BITS = ADDR_BITS - MIN_SHIFT;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_NOMEM    = 2'd1;
   localparam status_type STATUS_OVERSIZE = 2'd2;

   typedef logic cmd_type;
   localparam cmd_type CMD_ALLOC = 1'b0;
   localparam cmd_type CMD_FREE  = 1'b1;

   typedef logic [CLASS_BITS-1:0] class_type;

   typedef struct packed {
      logic [2:0]                pad;
      logic [ADDR_BITS-1:0]      page_addr;
      logic                      page_valid;
      logic [ADDR_BITS-1:0]      free_addr;
      logic [NBYTES_BITS-1:0]    nbytes;
      logic [CPU_FIELD_BITS-1:0] cpu;
   } req_data_type;

   typedef struct packed {
      logic                 pad;
      logic                 page_used;
      class_type            size_class;
      logic [ADDR_BITS-1:0] chunk_addr;
   } rsp_data_type;

   function automatic class_type class_of(input logic [6:0] units);
      class_type c;
      case (units) inside
         7'd0:           c = 4'd6;
         7'd1:           c = 4'd7;
         [7'd2:7'd3]:    c = 4'd8;
         [7'd4:7'd7]:    c = 4'd9;
         [7'd8:7'd15]:   c = 4'd10;
         [7'd16:7'd31]:  c = 4'd11;
         default:        c = 4'd12;
      endcase
      return c;
   endfunction

endpackage

// File: design/size_class_free_list_allocator_unit.sv
// Top level of the per-CPU size-class free-list allocator.
//
// req channel: one word per alloc or free request; req_tuser carries the command.
// rsp channel: one word per request, in request order; rsp_tuser carries the status.
// Each CPU owns seven LIFO lists (64 B to 4 KiB chunks). List heads live in a
// CPUS*7 entry RAM, chunk links in a HEAP_BYTES/64 entry RAM, both with
// registered read data. A request above a page is answered without touching
// either RAM; any other request reads its head first. A free then writes the
// head and one link; an alloc from a non-empty list reads the top chunk's link
// and writes it to the head; an alloc from an empty list with no page gives out
// of memory; page carving writes one link RAM entry per carved chunk.
// Reset clears the head RAM in a pass over all CPUS*7 entries with req_tready low;
// link RAM contents are not cleared.
// A result waits in an output register while rsp_tready is low; one more
// finished result is held behind it, after which req_tready stays low.
module size_class_free_list_allocator_unit #(
   parameter int CPUS       = 8,
   parameter int HEAP_BYTES = 262144
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // cpu, nbytes, free_addr, page_valid, page_addr, zero pad
   input  scfla_pkg::req_data_type req_tdata,
   // cmd
   input  scfla_pkg::cmd_type      req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // chunk_addr, size_class, page_used, zero pad
   output scfla_pkg::rsp_data_type rsp_tdata,
   // status
   output scfla_pkg::status_type   rsp_tuser
);

   import scfla_pkg::*;

   localparam int NCHUNKS   = HEAP_BYTES >> MIN_SHIFT;
   localparam int IDX_BITS  = $clog2(NCHUNKS);
   localparam int LINK_BITS = IDX_BITS + 1;
   localparam int SLOTS     = CPUS * NCLASSES;
   localparam int SLOT_BITS = $clog2(SLOTS);

   logic [SLOT_BITS-1:0] head_addr;
   logic                 head_we;
   logic [LINK_BITS-1:0] head_wdata;
   logic [LINK_BITS-1:0] head_rdata;
   logic [IDX_BITS-1:0]  link_addr;
   logic                 link_we;
   logic [LINK_BITS-1:0] link_wdata;
   logic [LINK_BITS-1:0] link_rdata;

   scfla_seq #(
      .CPUS       (CPUS),
      .HEAP_BYTES (HEAP_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .head_addr  (head_addr),
      .head_we    (head_we),
      .head_wdata (head_wdata),
      .head_rdata (head_rdata),
      .link_addr  (link_addr),
      .link_we    (link_we),
      .link_wdata (link_wdata),
      .link_rdata (link_rdata)
   );

   scfla_ram #(
      .DEPTH (SLOTS),
      .WIDTH (LINK_BITS)
   ) u_head_ram (
      .clock (clock),
      .addr  (head_addr),
      .we    (head_we),
      .wdata (head_wdata),
      .rdata (head_rdata)
   );

   scfla_ram #(
      .DEPTH (NCHUNKS),
      .WIDTH (LINK_BITS)
   ) u_link_ram (
      .clock (clock),
      .addr  (link_addr),
      .we    (link_we),
      .wdata (link_wdata),
      .rdata (link_rdata)
   );

endmodule

// File: design/scfla_ram.sv
// Single-port synchronous RAM with registered read data.
module scfla_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/scfla_seq.sv
// Request sequencer: head and link read-modify-write, page carving and result register.
module scfla_seq #(
   parameter int CPUS       = 8,
   parameter int HEAP_BYTES = 262144,
   localparam int NCHUNKS   = HEAP_BYTES >> scfla_pkg::MIN_SHIFT,
   localparam int IDX_BITS  = $clog2(NCHUNKS),
   localparam int LINK_BITS = IDX_BITS + 1,
   localparam int SLOTS     = CPUS * scfla_pkg::NCLASSES,
   localparam int SLOT_BITS = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  scfla_pkg::req_data_type req_tdata,
   input  scfla_pkg::cmd_type     req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output scfla_pkg::rsp_data_type rsp_tdata,
   output scfla_pkg::status_type  rsp_tuser,
   output logic [SLOT_BITS-1:0]   head_addr,
   output logic                   head_we,
   output logic [LINK_BITS-1:0]   head_wdata,
   input  logic [LINK_BITS-1:0]   head_rdata,
   output logic [IDX_BITS-1:0]    link_addr,
   output logic                   link_we,
   output logic [LINK_BITS-1:0]   link_wdata,
   input  logic [LINK_BITS-1:0]   link_rdata
);

   import scfla_pkg::*;

   localparam int CPU_BITS = (CPUS > 1) ? $clog2(CPUS) : 1;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_HEAD, ST_LINK, ST_CARVE} state_type;

   // wrap the raw chunk number into the heap by conditional subtraction
   function automatic logic [IDX_BITS-1:0] to_idx(input logic [CHUNK_RAW_BITS-1:0] raw);
      logic [CHUNK_RAW_BITS-1:0] rem;
      rem = raw;
      for (int k = CHUNK_RAW_BITS - MIN_SHIFT - 1; k >= 0; k--) begin
         if ((NCHUNKS << k) < (1 << CHUNK_RAW_BITS) &&
             rem >= CHUNK_RAW_BITS'(NCHUNKS << k)) begin
            rem = rem - CHUNK_RAW_BITS'(NCHUNKS << k);
         end
      end
      return IDX_BITS'(rem);
   endfunction

   function automatic logic [CPU_BITS-1:0] cpu_wrap(input logic [CPU_FIELD_BITS-1:0] cpu);
      logic [CPU_BITS-1:0] w;
      w = '0;
      for (int v = 0; v < (1 << CPU_FIELD_BITS); v++) begin
         if (cpu == CPU_FIELD_BITS'(v)) begin
            w = CPU_BITS'(v % CPUS);
         end
      end
      return w;
   endfunction

   function automatic logic [ADDR_BITS-1:0] to_addr(input logic [IDX_BITS-1:0] idx);
      return ADDR_BITS'({idx, {MIN_SHIFT{1'b0}}});
   endfunction

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   clr_ff, clr_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   cmd_type                cmd_ff, cmd_in;
   class_type              cls_ff, cls_in;
   logic [IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_BITS-1:0]    top_ff, top_in;
   logic [IDX_BITS-1:0]    prev_ff, prev_in;
   logic                   pv_ff, pv_in;
   logic [PAGE_HI_BITS-1:0] page_hi_ff, page_hi_in;
   logic [6:0]             off_ff, off_in;
   logic                   pend_ff, pend_in;
   status_type             pstat_ff, pstat_in;
   logic [ADDR_BITS-1:0]   paddr_ff, paddr_in;
   class_type              pcls_ff, pcls_in;
   logic                   pused_ff, pused_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;
   status_type             rsp_stat_ff, rsp_stat_in;

   logic [CPU_BITS-1:0]    cpu_mod;
   class_type              req_cls;
   logic                   oversize;
   logic [SLOT_BITS-1:0]   req_slot;
   logic                   out_free;
   logic                   emit;
   logic                   accept;
   logic [6:0]             step;
   logic [6:0]             off_next;
   logic [IDX_BITS-1:0]    carve_idx;
   logic [LINK_BITS-1:0]   carve_link;
   logic [IDX_BITS-1:0]    head_top;

   assign cpu_mod   = cpu_wrap(req_tdata.cpu);
   assign req_cls   = class_of(req_tdata.nbytes[NBYTES_BITS-1:MIN_SHIFT]);
   assign oversize  = req_tdata.nbytes > NBYTES_BITS'(PAGE_BYTES);
   assign req_slot  = SLOT_BITS'(32'(cpu_mod) * NCLASSES + 32'(req_cls) - MIN_SHIFT);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = pend_ff && out_free;
   assign req_tready = (state_ff == ST_IDLE) && (!pend_ff || out_free);
   assign accept    = req_tvalid && req_tready;
   assign step      = 7'd1 << 3'(cls_ff - CLASS_BITS'(MIN_SHIFT));
   assign off_next  = off_ff + step;
   assign carve_idx = to_idx({page_hi_ff, off_ff[5:0]});
   assign carve_link = (off_ff == 7'd0) ? '0 : LINK_BITS'(prev_ff) + LINK_BITS'(1);
   assign head_top  = IDX_BITS'(head_rdata - LINK_BITS'(1));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      cmd_in       = cmd_ff;
      cls_in       = cls_ff;
      free_idx_in  = free_idx_ff;
      top_in       = top_ff;
      prev_in      = prev_ff;
      pv_in        = pv_ff;
      page_hi_in   = page_hi_ff;
      off_in       = off_ff;
      pend_in      = pend_ff;
      pstat_in     = pstat_ff;
      paddr_in     = paddr_ff;
      pcls_in      = pcls_ff;
      pused_in     = pused_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      head_addr    = slot_ff;
      head_we      = 1'b0;
      head_wdata   = '0;
      link_addr    = free_idx_ff;
      link_we      = 1'b0;
      link_wdata   = '0;

      // drain pending result into the output register
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.pad        = 1'b0;
         rsp_data_in.page_used  = pused_ff;
         rsp_data_in.size_class = pcls_ff;
         rsp_data_in.chunk_addr = paddr_ff;
         rsp_stat_in            = pstat_ff;
         pend_in                = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            head_addr = clr_ff;
            head_we   = 1'b1;
            clr_in    = clr_ff + SLOT_BITS'(1);
            if (clr_ff == SLOT_BITS'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            head_addr = req_slot;
            if (accept) begin
               cmd_in      = req_tuser;
               slot_in     = req_slot;
               cls_in      = req_cls;
               free_idx_in = to_idx(req_tdata.free_addr[ADDR_BITS-1:MIN_SHIFT]);
               pv_in       = req_tdata.page_valid;
               page_hi_in  = req_tdata.page_addr[ADDR_BITS-1:MAX_SHIFT];
               off_in      = 7'd0;
               if (oversize) begin
                  pend_in  = 1'b1;
                  pstat_in = STATUS_OVERSIZE;
                  paddr_in = '0;
                  pcls_in  = CLASS_BITS'(MAX_SHIFT);
                  pused_in = 1'b0;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (cmd_ff == CMD_FREE) begin
               head_we    = 1'b1;
               head_wdata = LINK_BITS'(free_idx_ff) + LINK_BITS'(1);
               link_addr  = free_idx_ff;
               link_we    = 1'b1;
               link_wdata = head_rdata;
               pend_in    = 1'b1;
               pstat_in   = STATUS_OK;
               paddr_in   = '0;
               pcls_in    = cls_ff;
               pused_in   = 1'b0;
               state_in   = ST_IDLE;
            end else if (head_rdata != '0) begin
               link_addr = head_top;
               top_in    = head_top;
               state_in  = ST_LINK;
            end else if (!pv_ff) begin
               pend_in  = 1'b1;
               pstat_in = STATUS_NOMEM;
               paddr_in = '0;
               pcls_in  = cls_ff;
               pused_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CARVE;
            end
         end
         ST_LINK: begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
            pend_in    = 1'b1;
            pstat_in   = STATUS_OK;
            paddr_in   = to_addr(top_ff);
            pcls_in    = cls_ff;
            pused_in   = 1'b0;
            state_in   = ST_IDLE;
         end
         ST_CARVE: begin
            link_addr  = carve_idx;
            link_we    = 1'b1;
            link_wdata = carve_link;
            prev_in    = carve_idx;
            off_in     = off_next;
            if (off_next[6]) begin
               head_we    = 1'b1;
               head_wdata = carve_link;
               pend_in    = 1'b1;
               pstat_in   = STATUS_OK;
               paddr_in   = to_addr(carve_idx);
               pcls_in    = cls_ff;
               pused_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      cmd_ff      <= cmd_in;
      cls_ff      <= cls_in;
      free_idx_ff <= free_idx_in;
      top_ff      <= top_in;
      prev_ff     <= prev_in;
      pv_ff       <= pv_in;
      page_hi_ff  <= page_hi_in;
      off_ff      <= off_in;
      pstat_ff    <= pstat_in;
      paddr_ff    <= paddr_in;
      pcls_ff     <= pcls_in;
      pused_ff    <= pused_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

endmodule

// File: design/scfla_checker.sv
// Port-level checks for the free-list allocator and their binding to the top level.
module scfla_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input scfla_pkg::req_data_type req_tdata,
   input scfla_pkg::cmd_type      req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input scfla_pkg::rsp_data_type rsp_tdata,
   input scfla_pkg::status_type   rsp_tuser
);

   import scfla_pkg::*;

   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during head clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_fail_no_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |->
         rsp_tdata.chunk_addr == '0 && !rsp_tdata.page_used)
      else $error("failed request returned a chunk or used a page");

   a_oversize_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OVERSIZE |->
         rsp_tdata.size_class == CLASS_BITS'(MAX_SHIFT))
      else $error("oversize response with wrong size class");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata.size_class >= CLASS_BITS'(MIN_SHIFT) &&
         rsp_tdata.size_class <= CLASS_BITS'(MAX_SHIFT))
      else $error("size class out of range");

endmodule

bind size_class_free_list_allocator_unit scfla_checker u_scfla_checker (.*);

// File: bench/size_class_free_list_allocator_unit_tb.sv
// Self-checking testbench for the size-class free-list allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module size_class_free_list_allocator_unit_tb;
   import scfla_pkg::*;

   localparam int LIST_SLOTS   = 8 * NCLASSES;
   localparam int LINK_DEPTH   = 262144 >> MIN_SHIFT;
   localparam int RANDOM_ITEMS = 234;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      cmd_type              cmd;
      logic [2:0]           cpu;
      logic [12:0]          nbytes;
      logic [ADDR_BITS-1:0] free_addr;
      logic                 page_valid;
      logic [ADDR_BITS-1:0] page_addr;
   } alloc_req_type;

   typedef struct {
      status_type           status;
      logic [ADDR_BITS-1:0] chunk_addr;
      class_type            size_class;
      logic                 page_used;
   } alloc_rsp_type;

   typedef struct {
      alloc_req_type rq;
      bit            typed;
      alloc_rsp_type rsp;
   } table_row_type;

   typedef struct {
      logic [2:0]           cpu;
      class_type            size_class;
      logic [ADDR_BITS-1:0] addr;
   } held_chunk_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   req_data_type  req_tdata = '0;
   cmd_type       req_tuser = CMD_ALLOC;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   rsp_data_type  rsp_tdata;
   status_type    rsp_tuser;

   int            req_idle_pct = 0;
   int            rsp_idle_pct = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;

   logic [12:0]    list_heads [0:LIST_SLOTS-1];
   logic [12:0]    chunk_links [0:LINK_DEPTH-1];
   alloc_rsp_type  pending_rsp_q [$];
   held_chunk_type held_chunks [$];
   table_row_type  stim_table [$];

   size_class_free_list_allocator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic class_type class_for_bytes(input logic [12:0] nb);
      logic [6:0] units;
      class_type  c;
      units = nb[12:6];
      c = class_type'(MIN_SHIFT);
      for (int k = 0; k < 7; k++) begin
         if (units[k]) begin
            c = (k + 7 > MAX_SHIFT) ? class_type'(MAX_SHIFT) : class_type'(k + 7);
         end
      end
      return c;
   endfunction

   function automatic void link_push(input int slot, input logic [11:0] idx);
      chunk_links[idx] = list_heads[slot];
      list_heads[slot] = {1'b0, idx} + 13'd1;
   endfunction

   function automatic alloc_rsp_type predict_allocator(input alloc_req_type rq);
      alloc_rsp_type r;
      class_type     c;
      int            slot;
      int            off;
      logic [12:0]   top;
      r.status     = STATUS_OK;
      r.chunk_addr = '0;
      r.size_class = class_type'(MAX_SHIFT);
      r.page_used  = 1'b0;
      if (rq.nbytes > PAGE_BYTES) begin
         r.status = STATUS_OVERSIZE;
         return r;
      end
      c = class_for_bytes(rq.nbytes);
      r.size_class = c;
      slot = int'(rq.cpu) * NCLASSES + (int'(c) - MIN_SHIFT);
      if (rq.cmd == CMD_FREE) begin
         link_push(slot, rq.free_addr[ADDR_BITS-1:MIN_SHIFT]);
         return r;
      end
      if (list_heads[slot] == 13'd0) begin
         if (!rq.page_valid) begin
            r.status = STATUS_NOMEM;
            return r;
         end
         for (off = 0; off < PAGE_BYTES; off += (1 << c)) begin
            link_push(slot, {rq.page_addr[ADDR_BITS-1:MAX_SHIFT], 6'b0} + 12'(off >> MIN_SHIFT));
         end
         r.page_used = 1'b1;
      end
      top = list_heads[slot] - 13'd1;
      list_heads[slot] = chunk_links[top[11:0]];
      r.chunk_addr = {top[11:0], 6'b0};
      return r;
   endfunction

   task automatic add_row(input cmd_type cmd, input int cpu, input int nbytes,
                          input int free_addr, input bit page_valid, input int page_addr,
                          input bit typed, input status_type status, input int chunk,
                          input int size_class, input bit page_used);
      table_row_type row;
      row.rq.cmd          = cmd;
      row.rq.cpu          = 3'(cpu);
      row.rq.nbytes       = 13'(nbytes);
      row.rq.free_addr    = ADDR_BITS'(free_addr);
      row.rq.page_valid   = page_valid;
      row.rq.page_addr    = ADDR_BITS'(page_addr);
      row.typed           = typed;
      row.rsp.status      = status;
      row.rsp.chunk_addr  = ADDR_BITS'(chunk);
      row.rsp.size_class  = class_type'(size_class);
      row.rsp.page_used   = page_used;
      stim_table.push_back(row);
   endtask

   function automatic logic [12:0] bytes_in_class(input int c);
      int lo;
      int hi;
      lo = (c == MIN_SHIFT) ? 0 : (1 << (c - 1));
      hi = (c == MAX_SHIFT) ? PAGE_BYTES : ((1 << c) - 1);
      return 13'($urandom_range(hi, lo));
   endfunction

   function automatic alloc_req_type random_request();
      alloc_req_type  rq;
      held_chunk_type h;
      int             pick;
      int             r;
      r = $urandom_range(99);
      rq.cmd        = CMD_ALLOC;
      rq.cpu        = 3'($urandom_range(7));
      rq.nbytes     = bytes_in_class($urandom_range(MAX_SHIFT, MIN_SHIFT));
      rq.free_addr  = ADDR_BITS'($urandom);
      rq.page_valid = ($urandom_range(99) < 70);
      rq.page_addr  = ADDR_BITS'($urandom);
      if (r >= 45 && r < 80) begin
         if (held_chunks.size() != 0) begin
            pick = $urandom_range(held_chunks.size() - 1);
            h = held_chunks[pick];
            held_chunks.delete(pick);
            rq.cmd = CMD_FREE;
            if ($urandom_range(9) != 0) begin
               rq.cpu = h.cpu;
            end
            rq.nbytes = bytes_in_class(int'(h.size_class));
            rq.free_addr = h.addr;
            if ($urandom_range(3) == 0) begin
               rq.free_addr[MIN_SHIFT-1:0] = 6'($urandom);
            end
         end else begin
            rq.page_valid = 1'b1;
         end
      end else if (r >= 80 && r < 90) begin
         rq.cmd    = CMD_FREE;
         rq.nbytes = 13'($urandom_range(PAGE_BYTES));
      end else if (r >= 90 && r < 97) begin
         rq.cmd    = cmd_type'($urandom_range(1));
         rq.nbytes = 13'($urandom_range(8191, PAGE_BYTES + 1));
      end else if (r >= 97) begin
         rq.nbytes = 13'($urandom_range(8191));
      end
      return rq;
   endfunction

   task automatic send_request(input alloc_req_type rq, input bit typed,
                               input alloc_rsp_type typed_rsp);
      alloc_rsp_type  predicted;
      req_data_type   w;
      held_chunk_type h;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      w            = '0;
      w.cpu        = rq.cpu;
      w.nbytes     = rq.nbytes;
      w.free_addr  = rq.free_addr;
      w.page_valid = rq.page_valid;
      w.page_addr  = rq.page_addr;
      req_tdata    = w;
      req_tuser    = rq.cmd;
      req_tvalid   = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_allocator(rq);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      if (rq.cmd == CMD_ALLOC && predicted.status == STATUS_OK) begin
         h.cpu        = rq.cpu;
         h.size_class = predicted.size_class;
         h.addr       = predicted.chunk_addr;
         held_chunks.push_back(h);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected word status=%0d chunk=%h class=%0d used=%0b",
                     $time, rsp_tuser, rsp_tdata.chunk_addr, rsp_tdata.size_class,
                     rsp_tdata.page_used);
            mismatch_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata.chunk_addr !== want.chunk_addr ||
                rsp_tdata.size_class !== want.size_class ||
                rsp_tdata.page_used !== want.page_used) begin
               $display("%0t: expected %0d/%h/%0d/%0b, got %0d/%h/%0d/%0b",
                        $time, want.status, want.chunk_addr, want.size_class, want.page_used,
                        rsp_tuser, rsp_tdata.chunk_addr, rsp_tdata.size_class,
                        rsp_tdata.page_used);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("size_class_free_list_allocator_unit_tb NOT OK");
      $finish;
   end

   initial begin
      alloc_rsp_type unused_rsp;
      unused_rsp = '{default: '0};
      foreach (list_heads[i]) list_heads[i] = 13'd0;
      foreach (chunk_links[i]) chunk_links[i] = 13'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(CMD_ALLOC, 0, 0, 0, 0, 0, 1, STATUS_NOMEM, 0, 6, 0);
      add_row(CMD_ALLOC, 7, 4096, 0, 0, 0, 1, STATUS_NOMEM, 0, 12, 0);
      add_row(CMD_ALLOC, 0, 8191, 'h3FFFF, 1, 'h3FFFF, 1, STATUS_OVERSIZE, 0, 12, 0);
      add_row(CMD_FREE, 3, 4097, 'h3FFFF, 0, 0, 1, STATUS_OVERSIZE, 0, 12, 0);
      add_row(CMD_ALLOC, 1, 0, 0, 1, 'h01FFF, 1, STATUS_OK, 'h01FC0, 6, 1);
      add_row(CMD_ALLOC, 1, 63, 0, 1, 'h02000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 7, 4096, 0, 1, 'h3F000, 1, STATUS_OK, 'h3F000, 12, 1);
      add_row(CMD_ALLOC, 7, 4096, 0, 0, 0, 1, STATUS_NOMEM, 0, 12, 0);
      add_row(CMD_FREE, 7, 4096, 'h3FFFF, 0, 0, 1, STATUS_OK, 0, 12, 0);
      add_row(CMD_ALLOC, 7, 2049, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_FREE, 2, 64, 0, 0, 0, 1, STATUS_OK, 0, 7, 0);
      add_row(CMD_FREE, 2, 127, 'h00040, 0, 0, 1, STATUS_OK, 0, 7, 0);
      add_row(CMD_ALLOC, 2, 100, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 2, 65, 0, 1, 'h0A000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 2, 64, 0, 0, 0, 1, STATUS_NOMEM, 0, 7, 0);
      add_row(CMD_FREE, 4, 1, 'h12340, 0, 0, 1, STATUS_OK, 0, 6, 0);
      add_row(CMD_FREE, 4, 1, 'h12340, 0, 0, 1, STATUS_OK, 0, 6, 0);
      add_row(CMD_ALLOC, 4, 1, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 4, 1, 0, 1, 'h05000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 6, 200, 0, 1, 'h20000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 6, 300, 0, 1, 'h21000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 6, 600, 0, 1, 'h22000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_ALLOC, 6, 1500, 0, 1, 'h23000, 0, STATUS_OK, 0, 0, 0);
      add_row(CMD_FREE, 5, 4096, 'h1F000, 0, 0, 1, STATUS_OK, 0, 12, 0);
      add_row(CMD_ALLOC, 5, 2048, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);

      req_idle_pct = 34;
      rsp_idle_pct = 62;
      foreach (stim_table[i]) begin
         send_request(stim_table[i].rq, stim_table[i].typed, stim_table[i].rsp);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 34;
               rsp_idle_pct = 62;
            end
            1: begin
               req_idle_pct = 62;
               rsp_idle_pct = 34;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_ITEMS) send_request(random_request(), 1'b0, unused_rsp);
      end
      req_tvalid = 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("size_class_free_list_allocator_unit_tb OK");
      end else begin
         $display("size_class_free_list_allocator_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
